// ===== design/wmsmm_pkg.sv =====
// wmsmm_pkg: shared types and constants for the window statistics core
// used by the controller, the datapath and the top level

package wmsmm_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int HALF_W    = 4;
	localparam int CNT_W     = 10;
	localparam int STD_W     = 24;
	localparam int WIN_W     = 20;
	localparam int DIV_W     = 20;
	localparam int SQ_VW     = 64;
	localparam int ROOT_W    = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = 10'h3FF;
	localparam logic [STD_W-1:0] STD_MAX = 24'hFFFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_ROW = 3'd0,
		CFG_CENTER_COL = 3'd1,
		CFG_HALF_SIZE  = 3'd2,
		CFG_IMAGE_ROWS = 3'd3,
		CFG_IMAGE_COLS = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MUL_LOAD,
		OP_MUL_STEP,
		OP_DIVM_LOAD,
		OP_DIVV_LOAD,
		OP_DIV_STEP,
		OP_SQRT_LOAD,
		OP_SQRT_STEP
	} op_t;

	typedef enum logic [3:0] {
		S_IN,
		S_MLOAD,
		S_MUL,
		S_DLM,
		S_DIVM,
		S_DLV,
		S_DIVV,
		S_QLOAD,
		S_SQRT,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic done;
	} dp_stat_t;

endpackage

// ===== design/wmsmm_if.sv =====
// wmsmm_if: valid/ready channel interfaces for pixel words and result words
// depends on nothing

interface wmsmm_pix_if #(parameter int PW = 24);
	logic                 valid;
	logic                 ready;
	logic signed [PW-1:0] pixel_value;
	logic                 frame_start;

	modport source(output valid, output pixel_value, output frame_start, input ready);
	modport sink(input valid, input pixel_value, input frame_start, output ready);
endinterface

interface wmsmm_res_if #(parameter int PW = 24);
	logic                 valid;
	logic                 ready;
	logic signed [PW-1:0] mean_value;
	logic [23:0]          std_value;
	logic signed [PW-1:0] min_value;
	logic signed [PW-1:0] max_value;
	logic [9:0]           pixel_count;
	logic                 single_pixel;

	modport source(output valid, output mean_value, output std_value, output min_value,
		output max_value, output pixel_count, output single_pixel, input ready);
	modport sink(input valid, input mean_value, input std_value, input min_value,
		input max_value, input pixel_count, input single_pixel, output ready);
endinterface

// ===== design/wmsmm_ctrl.sv =====
// wmsmm_ctrl: sequencer for pixel intake, multiply, divide and root phases
// depends on wmsmm_pkg

module wmsmm_ctrl import wmsmm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_ACCEPT;
					if (stat.last) state_d = S_MLOAD;
				end
			end
			S_MLOAD: begin
				cmd.op  = OP_MUL_LOAD;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op = OP_MUL_STEP;
				if (stat.done) state_d = S_DLM;
			end
			S_DLM: begin
				cmd.op  = OP_DIVM_LOAD;
				state_d = S_DIVM;
			end
			S_DIVM: begin
				cmd.op = OP_DIV_STEP;
				if (stat.done) state_d = S_DLV;
			end
			S_DLV: begin
				cmd.op  = OP_DIVV_LOAD;
				state_d = S_DIVV;
			end
			S_DIVV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.done) state_d = S_QLOAD;
			end
			S_QLOAD: begin
				cmd.op  = OP_SQRT_LOAD;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				if (stat.done) state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IN;
			end
			default: state_d = S_IN;
		endcase
	end

	a_no_intake_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("pixel intake open while result pending");

	a_last_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && stat.last) |=> (state_q == S_MLOAD))
		else $error("last window pixel did not start computation");

	a_out_returns_intake: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready) else $error("intake not reopened");

endmodule

// ===== design/wmsmm_dp.sv =====
// wmsmm_dp: datapath with config registers, position counters, accumulators,
// shift-add multipliers, restoring divider and digit-by-digit square root; uses wmsmm_pkg

module wmsmm_dp import wmsmm_pkg::*; #(
	parameter int MAX_HALF_SIZE = 15,
	parameter int MAX_IMAGE_DIM = 4096,
	parameter int PIXEL_WIDTH   = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat,
	input  logic signed [PIXEL_WIDTH-1:0] pixel_value,
	input  logic                          frame_start,
	output logic signed [PIXEL_WIDTH-1:0] mean_value,
	output logic [STD_W-1:0]              std_value,
	output logic signed [PIXEL_WIDTH-1:0] min_value,
	output logic signed [PIXEL_WIDTH-1:0] max_value,
	output logic [CNT_W-1:0]              pixel_count,
	output logic                          single_pixel
);

	localparam int PW  = PIXEL_WIDTH;
	localparam int SW  = PW + CNT_W;
	localparam int SQW = (2 * PW + CNT_W > 64) ? 64 : 2 * PW + CNT_W;
	localparam int NA  = SQW + CNT_W;
	localparam int NB  = 2 * SW;
	localparam int NW0 = (NA > NB) ? NA : NB;
	localparam int NW  = (NW0 > SQ_VW + 1) ? NW0 : SQ_VW + 1;
	localparam int SCW = $clog2(NW);
	localparam int IW  = (MAX_IMAGE_DIM > 1) ? $clog2(MAX_IMAGE_DIM) : 1;

	localparam logic signed [PW-1:0] PIX_MAXV = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] PIX_MINV = {1'b1, {(PW-1){1'b0}}};

	logic [CFG_W-1:0]  ctr_row_q, ctr_col_q, img_rows_q, img_cols_q;
	logic [HALF_W-1:0] half_q;

	logic [IW-1:0]          row_q, col_q;
	logic signed [SW-1:0]   sum_q;
	logic [SQW-1:0]         sq_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [PW-1:0]   min_q, max_q;

	logic [NW-1:0]          a_acc_q, a_mc_q, b_acc_q, b_mc_q;
	logic [CNT_W-1:0]       a_mp_q;
	logic [SW-1:0]          b_mp_q, smag_q;
	logic                   neg_q, ge_q;
	logic [DIV_W-1:0]       d_q, dd_q, rm_q;
	logic [NW-1:0]          dv_q;
	logic [SCW-1:0]         stp_q;
	logic [SQ_VW-1:0]       v_q;
	logic [ROOT_W+1:0]      rem_q;
	logic [ROOT_W-1:0]      root_q;
	logic signed [PW-1:0]   mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_row_q  <= CFG_W'(1);
			ctr_col_q  <= CFG_W'(1);
			half_q     <= '0;
			img_rows_q <= CFG_W'(1);
			img_cols_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_ROW: ctr_row_q  <= cfg_data;
				CFG_CENTER_COL: ctr_col_q  <= cfg_data;
				CFG_HALF_SIZE:  half_q     <= cfg_data[HALF_W-1:0];
				CFG_IMAGE_ROWS: img_rows_q <= cfg_data;
				CFG_IMAGE_COLS: img_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// window bounds and position
	logic [WIN_W-1:0]        rows_w, cols_w;
	logic signed [WIN_W-1:0] h_w, lo_r, hi_r, lo_c, hi_c, r1, c1;
	logic [IW-1:0]           er, ec, row_n, col_n;
	logic                    clr, in_win, take;

	always_comb begin
		rows_w = WIN_W'(img_rows_q);
		if (rows_w == '0) rows_w = WIN_W'(1);
		else if (rows_w > WIN_W'(MAX_IMAGE_DIM)) rows_w = WIN_W'(MAX_IMAGE_DIM);
		cols_w = WIN_W'(img_cols_q);
		if (cols_w == '0) cols_w = WIN_W'(1);
		else if (cols_w > WIN_W'(MAX_IMAGE_DIM)) cols_w = WIN_W'(MAX_IMAGE_DIM);
		h_w = (WIN_W'(half_q) > WIN_W'(MAX_HALF_SIZE)) ? WIN_W'(MAX_HALF_SIZE) : WIN_W'(half_q);
		lo_r = signed'(WIN_W'(ctr_row_q)) - h_w;
		if (lo_r < WIN_W'(1)) lo_r = WIN_W'(1);
		hi_r = signed'(WIN_W'(ctr_row_q)) + h_w;
		if (hi_r > signed'(rows_w)) hi_r = signed'(rows_w);
		lo_c = signed'(WIN_W'(ctr_col_q)) - h_w;
		if (lo_c < WIN_W'(1)) lo_c = WIN_W'(1);
		hi_c = signed'(WIN_W'(ctr_col_q)) + h_w;
		if (hi_c > signed'(cols_w)) hi_c = signed'(cols_w);
		er  = frame_start ? '0 : row_q;
		ec  = frame_start ? '0 : col_q;
		clr = (er == '0) && (ec == '0);
		r1  = signed'(WIN_W'(er)) + WIN_W'(1);
		c1  = signed'(WIN_W'(ec)) + WIN_W'(1);
		in_win = (r1 >= lo_r) && (r1 <= hi_r) && (c1 >= lo_c) && (c1 <= hi_c);
		if (c1 >= signed'(cols_w)) begin
			col_n = '0;
			row_n = (r1 >= signed'(rows_w)) ? '0 : IW'(r1);
		end else begin
			col_n = IW'(c1);
			row_n = er;
		end
	end

	// accumulator update
	logic signed [SW-1:0] b_sum;
	logic [SQW-1:0]       b_sq;
	logic [CNT_W-1:0]     b_cnt;
	logic signed [PW-1:0] b_min, b_max;
	logic [PW-1:0]        mag;
	logic [2*PW-1:0]      msq;

	always_comb begin
		b_sum = clr ? '0 : sum_q;
		b_sq  = clr ? '0 : sq_q;
		b_cnt = clr ? '0 : cnt_q;
		b_min = clr ? PIX_MAXV : min_q;
		b_max = clr ? PIX_MINV : max_q;
		take  = in_win && (b_cnt != CNT_MAX);
		mag   = (pixel_value < 0) ? PW'(-pixel_value) : PW'(pixel_value);
		msq   = {{PW{1'b0}}, mag} * {{PW{1'b0}}, mag};
	end

	always_comb begin
		stat.last = in_win && (r1 == hi_r) && (c1 == hi_c);
		case (cmd.op)
			OP_MUL_STEP:  stat.done = (stp_q == SCW'(SW - 1));
			OP_DIV_STEP:  stat.done = (stp_q == SCW'(NW - 1));
			OP_SQRT_STEP: stat.done = (stp_q == SCW'(ROOT_W - 1));
			default:      stat.done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
			cnt_q <= '0;
			min_q <= PIX_MAXV;
			max_q <= PIX_MINV;
		end else if (cmd.op == OP_ACCEPT) begin
			row_q <= row_n;
			col_q <= col_n;
			sum_q <= take ? b_sum + SW'(pixel_value) : b_sum;
			sq_q  <= take ? b_sq + SQW'(msq) : b_sq;
			cnt_q <= take ? b_cnt + CNT_W'(1) : b_cnt;
			min_q <= (take && pixel_value < b_min) ? pixel_value : b_min;
			max_q <= (take && pixel_value > b_max) ? pixel_value : b_max;
		end
	end

	// divide and root step logic
	logic [SW-1:0]     smag;
	logic [DIV_W:0]    rsh;
	logic              qb;
	logic [DIV_W-1:0]  rm_n;
	logic [ROOT_W+3:0] qsh, trial;
	logic              sb;
	logic signed [SW-1:0] mq;

	always_comb begin
		smag = (sum_q < 0) ? SW'(-sum_q) : SW'(sum_q);
		rsh  = {rm_q, dv_q[NW-1]};
		qb   = (rsh >= {1'b0, dd_q});
		rm_n = qb ? DIV_W'(rsh - {1'b0, dd_q}) : rsh[DIV_W-1:0];
		qsh  = {rem_q, v_q[SQ_VW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		sb   = (qsh >= trial);
		mq   = signed'(dv_q[SW-1:0]);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_MUL_LOAD: begin
				a_acc_q <= '0;
				a_mc_q  <= NW'(sq_q);
				a_mp_q  <= cnt_q;
				b_acc_q <= '0;
				b_mc_q  <= NW'(smag);
				b_mp_q  <= smag;
				smag_q  <= smag;
				neg_q   <= (sum_q < 0);
				d_q     <= {{CNT_W{1'b0}}, cnt_q} * {{CNT_W{1'b0}}, cnt_q - CNT_W'(1)};
				stp_q   <= '0;
			end
			OP_MUL_STEP: begin
				if (a_mp_q[0]) a_acc_q <= a_acc_q + a_mc_q;
				if (b_mp_q[0]) b_acc_q <= b_acc_q + b_mc_q;
				a_mc_q <= a_mc_q << 1;
				a_mp_q <= a_mp_q >> 1;
				b_mc_q <= b_mc_q << 1;
				b_mp_q <= b_mp_q >> 1;
				stp_q  <= stp_q + SCW'(1);
			end
			OP_DIVM_LOAD: begin
				dv_q  <= NW'(smag_q);
				rm_q  <= '0;
				dd_q  <= DIV_W'(cnt_q);
				stp_q <= '0;
			end
			OP_DIVV_LOAD: begin
				mean_q <= neg_q ? PW'(-mq) : PW'(mq);
				ge_q   <= (a_acc_q >= b_acc_q);
				dv_q   <= (a_acc_q >= b_acc_q) ? a_acc_q - b_acc_q : '0;
				rm_q   <= '0;
				dd_q   <= d_q;
				stp_q  <= '0;
			end
			OP_DIV_STEP: begin
				dv_q  <= {dv_q[NW-2:0], qb};
				rm_q  <= rm_n;
				stp_q <= stp_q + SCW'(1);
			end
			OP_SQRT_LOAD: begin
				v_q    <= (|dv_q[NW-1:SQ_VW]) ? {SQ_VW{1'b1}} : dv_q[SQ_VW-1:0];
				rem_q  <= '0;
				root_q <= '0;
				stp_q  <= '0;
			end
			OP_SQRT_STEP: begin
				rem_q  <= sb ? (ROOT_W+2)'(qsh - trial) : (ROOT_W+2)'(qsh);
				root_q <= {root_q[ROOT_W-2:0], sb};
				v_q    <= v_q << 2;
				stp_q  <= stp_q + SCW'(1);
			end
			default: ;
		endcase
	end

	assign mean_value   = mean_q;
	assign std_value    = (cnt_q > CNT_W'(1) && ge_q)
		? ((root_q > ROOT_W'(STD_MAX)) ? STD_MAX : root_q[STD_W-1:0]) : '0;
	assign min_value    = min_q;
	assign max_value    = max_q;
	assign pixel_count  = cnt_q;
	assign single_pixel = (cnt_q == CNT_W'(1));

endmodule

// ===== design/window_mean_std_min_max_core.sv =====
// Window statistics core: pixels stream in raster order, one word per cycle while the
// core is collecting. Pixels inside the clipped square window feed count, sum, square
// sum, min and max. After the last window pixel the core stops taking words while it runs
// a shift-add multiply, two restoring divides one quotient bit per cycle, and a
// two-bits-per-cycle square root. The result word then holds until taken, and intake
// resumes the cycle after. Depends on wmsmm_pkg, wmsmm_if, wmsmm_ctrl, wmsmm_dp.

module window_mean_std_min_max_core import wmsmm_pkg::*; #(
	parameter int MAX_HALF_SIZE = 15,
	parameter int MAX_IMAGE_DIM = 4096,
	parameter int PIXEL_WIDTH   = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	wmsmm_pix_if.sink            pixel_in,
	wmsmm_res_if.source          result_out
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	wmsmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.cmd       (cmd),
		.in_valid  (pixel_in.valid),
		.in_ready  (pixel_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready)
	);

	wmsmm_dp #(
		.MAX_HALF_SIZE (MAX_HALF_SIZE),
		.MAX_IMAGE_DIM (MAX_IMAGE_DIM),
		.PIXEL_WIDTH   (PIXEL_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.pixel_value  (pixel_in.pixel_value),
		.frame_start  (pixel_in.frame_start),
		.mean_value   (result_out.mean_value),
		.std_value    (result_out.std_value),
		.min_value    (result_out.min_value),
		.max_value    (result_out.max_value),
		.pixel_count  (result_out.pixel_count),
		.single_pixel (result_out.single_pixel)
	);

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for window_mean_std_min_max_core, with its own statistics predictor
// drives pixel words and register writes, checks every result word against the prediction
// depends on wmsmm_pkg, wmsmm_if and the core
`timescale 1ns / 100ps

module tb;
	import wmsmm_pkg::*;

	typedef struct {
		logic signed [23:0] mean_value;
		logic [23:0]        std_value;
		logic signed [23:0] min_value;
		logic signed [23:0] max_value;
		logic [9:0]         pixel_count;
		logic               single_pixel;
	} stats_t;

	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 250;
	localparam int RAND_ITEMS  = 1800;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	wmsmm_pix_if #(.PW(24)) pix();
	wmsmm_res_if #(.PW(24)) res();

	window_mean_std_min_max_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel_in(pix), .result_out(res)
	);

	// predictor state
	logic [12:0] win_row, win_col, img_rows, img_cols;
	logic [3:0]  win_half;
	int          row_pos, col_pos, acc_count;
	longint      acc_sum, acc_min, acc_max;
	logic [63:0] acc_sq;

	stats_t expected_stats[$];
	int     mismatches;
	int     words_sent;
	int     idle_cycles;
	int     ready_stall;
	bit     burst;
	bit     pix_high;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int pick_gap();
		if (burst)
			return 0;
		if ($urandom_range(0, 9) < 7)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [23:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return -24'sh800000;
			2: return 24'($signed($urandom_range(0, 512)) - 256);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0]  r;
		logic [63:0]  t;
		logic [127:0] t2;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			t2 = 128'(t) * 128'(t);
			if (t2 <= 128'(v))
				r = t;
		end
		return r;
	endfunction

	task automatic clear_stats();
		acc_count = 0;
		acc_sum = 0;
		acc_sq = '0;
		acc_min = 64'sd8388607;
		acc_max = -64'sd8388608;
	endtask

	task automatic predict_word(input logic signed [23:0] pv, input logic fs);
		int           rows, cols, h, lo_r, hi_r, lo_c, hi_c, r1, c1;
		longint       p, mag, smag;
		logic [127:0] a, b, v;
		logic [63:0]  var64, root;
		stats_t       e;
		p = pv;
		rows = (img_rows < 1) ? 1 : ((img_rows > 4096) ? 4096 : int'(img_rows));
		cols = (img_cols < 1) ? 1 : ((img_cols > 4096) ? 4096 : int'(img_cols));
		h = win_half;
		if (fs) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (row_pos == 0 && col_pos == 0)
			clear_stats();
		lo_r = int'(win_row) - h;
		if (lo_r < 1) lo_r = 1;
		hi_r = int'(win_row) + h;
		if (hi_r > rows) hi_r = rows;
		lo_c = int'(win_col) - h;
		if (lo_c < 1) lo_c = 1;
		hi_c = int'(win_col) + h;
		if (hi_c > cols) hi_c = cols;
		r1 = row_pos + 1;
		c1 = col_pos + 1;
		if (r1 >= lo_r && r1 <= hi_r && c1 >= lo_c && c1 <= hi_c) begin
			if (acc_count < int'(CNT_MAX)) begin
				mag = (p < 0) ? -p : p;
				acc_sum += p;
				acc_sq += 64'(mag) * 64'(mag);
				acc_count++;
				if (p < acc_min) acc_min = p;
				if (p > acc_max) acc_max = p;
			end
			if (r1 == hi_r && c1 == hi_c) begin
				e.mean_value = 24'(acc_sum / longint'(acc_count));
				e.std_value = '0;
				if (acc_count > 1) begin
					smag = (acc_sum < 0) ? -acc_sum : acc_sum;
					a = 128'(acc_sq) * 128'(acc_count);
					b = 128'(smag) * 128'(smag);
					if (a >= b) begin
						v = (a - b) / (128'(acc_count) * 128'(acc_count - 1));
						var64 = (v > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : v[63:0];
						root = isqrt(var64);
						e.std_value = (root > 64'(STD_MAX)) ? STD_MAX : root[23:0];
					end
				end
				e.min_value = 24'(acc_min);
				e.max_value = 24'(acc_max);
				e.pixel_count = 10'(acc_count);
				e.single_pixel = (acc_count == 1);
				expected_stats.push_back(e);
			end
		end
		col_pos++;
		if (col_pos >= cols) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= rows)
				row_pos = 0;
		end
	endtask

	task automatic send_word(input logic signed [23:0] pv, input logic fs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			if (pix_high)
				pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_value <= pv;
		pix.frame_start <= fs;
		pix_high = 1'b1;
		do
			@(posedge clk);
		while (!pix.ready);
		predict_word(pv, fs);
		words_sent++;
	endtask

	task automatic wait_idle();
		if (pix_high)
			pix.valid <= 1'b0;
		pix_high = 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CENTER_ROW: win_row = val;
			CFG_CENTER_COL: win_col = val;
			CFG_HALF_SIZE:  win_half = val[3:0];
			CFG_IMAGE_ROWS: img_rows = val;
			CFG_IMAGE_COLS: img_cols = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_window(input logic [12:0] cr, input logic [12:0] cc, input logic [3:0] hs,
		input logic [12:0] nr, input logic [12:0] nc);
		wait_idle();
		write_reg(CFG_CENTER_ROW, cr);
		write_reg(CFG_CENTER_COL, cc);
		write_reg(CFG_HALF_SIZE, 13'(hs));
		write_reg(CFG_IMAGE_ROWS, nr);
		write_reg(CFG_IMAGE_COLS, nc);
	endtask

	// reset settings: every pixel is a one-pixel frame
	task automatic test_single_pixel();
		send_word(24'sh7FFFFF, 1'b1);
		send_word(-24'sh800000, 1'b0);
		send_word(24'sh000000, 1'b1);
		send_word(-24'sh000001, 1'b0);
		send_word(24'sh555555, 1'b0);
		send_word(24'shAAAAAA, 1'b1);
	endtask

	// full 3x3 window of extremes, then a clipped corner
	task automatic test_window_extremes();
		set_window(13'd2, 13'd2, 4'd1, 13'd3, 13'd3);
		for (int i = 0; i < 9; i++)
			send_word((i % 2) ? 24'sh7FFFFF : -24'sh800000, i == 0);
		set_window(13'd1, 13'd1, 4'd15, 13'd2, 13'd2);
		for (int i = 0; i < 4; i++)
			send_word(24'sh7FFFFF, i == 0);
		// empty window: centre row 0 with no half width
		set_window(13'd0, 13'd1, 4'd0, 13'd2, 13'd2);
		for (int i = 0; i < 4; i++)
			send_word(rand_pixel(), i == 0);
	endtask

	// dimension registers beyond range, long rows
	task automatic test_register_limits();
		set_window(13'd1, 13'd20, 4'd15, 13'd0, 13'h1FFF);
		for (int i = 0; i < 40; i++)
			send_word(rand_pixel(), i == 0);
		set_window(13'h1FFF, 13'h1FFF, 4'd15, 13'd4096, 13'd4);
		for (int i = 0; i < 20; i++)
			send_word(rand_pixel(), i == 0);
	endtask

	task automatic test_random_frames();
		int nr, nc, frames, stop;
		logic [12:0] cr, cc, r_reg, c_reg;
		logic [3:0] hs;
		while (words_sent < RAND_ITEMS) begin
			nr = $urandom_range(1, 12);
			nc = $urandom_range(1, 12);
			cr = 13'($urandom_range(0, nr + 2));
			cc = 13'($urandom_range(0, nc + 2));
			hs = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
			r_reg = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'(nr);
			c_reg = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'(nc);
			if (r_reg == 0) nr = 1;
			if (c_reg == 0) nc = 1;
			set_window(cr, cc, hs, r_reg, c_reg);
			burst = ($urandom_range(0, 4) == 0);
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nr * nc) : nr * nc;
				for (int i = 0; i < stop; i++)
					send_word(rand_pixel(), (i == 0 && $urandom_range(0, 9) != 0) ||
						$urandom_range(0, 39) == 0);
			end
			burst = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			ready_stall = 0;
		end else if (ready_stall > 0) begin
			res.ready <= 1'b0;
			ready_stall--;
		end else begin
			res.ready <= 1'b1;
			if ($urandom_range(0, 2) == 0)
				ready_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		stats_t e;
		if (arst_n && res.valid && res.ready) begin
			if (expected_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: mean %0d count %0d", res.mean_value,
						res.pixel_count);
			end else begin
				e = expected_stats.pop_front();
				if (res.mean_value !== e.mean_value || res.std_value !== e.std_value ||
					res.min_value !== e.min_value || res.max_value !== e.max_value ||
					res.pixel_count !== e.pixel_count || res.single_pixel !== e.single_pixel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp mean %0d std %0d min %0d max %0d cnt %0d single %0b, got mean %0d std %0d min %0d max %0d cnt %0d single %0b",
							e.mean_value, e.std_value, e.min_value, e.max_value, e.pixel_count,
							e.single_pixel, res.mean_value, res.std_value, res.min_value,
							res.max_value, res.pixel_count, res.single_pixel);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pix.valid <= 1'b0;
		pix.pixel_value <= '0;
		pix.frame_start <= 1'b0;
		pix_high = 1'b0;
		burst = 1'b0;
		mismatches = 0;
		words_sent = 0;
		idle_cycles = 0;
		win_row = 13'd1;
		win_col = 13'd1;
		win_half = 4'd0;
		img_rows = 13'd1;
		img_cols = 13'd1;
		row_pos = 0;
		col_pos = 0;
		clear_stats();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_pixel();
		test_window_extremes();
		test_register_limits();
		test_random_frames();
		wait_idle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== window_mean_std_min_max_core.f =====
design/wmsmm_pkg.sv
design/wmsmm_if.sv
design/wmsmm_ctrl.sv
design/wmsmm_dp.sv
design/window_mean_std_min_max_core.sv
dv/tb.sv
